// ===== src/cfq_pkg.sv =====
package cfq_pkg;

    localparam int DEF_DEPTH = 64;
    localparam int DATA_W    = 32;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;

    localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
    localparam logic [OP_W-1:0] OP_DISPLAY = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic enq;       // store beat value at tail, load ok result
        logic ld_ovf;    // load overflow result
        logic ld_empty;  // load empty result
        logic rd_start;  // read at head, start the walk
        logic rd_next;   // read at walk index, advance it
        logic ld_data;   // load result from the read data
        logic ld_last;   // last flag for ld_data
        logic deq_adv;   // pop: advance head, decrement count
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
        logic out_free;  // output register can take a result this cycle
        logic rem_one;   // one entry left in the walk
    } t_dp_stat;

endpackage

// ===== src/cfq_if.sv =====
interface cfq_in_if
    import cfq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] item_value;

    modport source(output valid, output opcode, output item_value, input ready);
    modport sink(input valid, input opcode, input item_value, output ready);
endinterface

interface cfq_out_if
    import cfq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [ST_W-1:0]          status;
    logic                     has_data;
    logic signed [DATA_W-1:0] data_value;
    logic                     last;

    modport source(output valid, output status, output has_data, output data_value,
                   output last, input ready);
    modport sink(input valid, input status, input has_data, input data_value,
                 input last, output ready);
endinterface

// ===== src/cfq_ram.sv =====
module cfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/cfq_dp.sv =====
module cfq_dp
    import cfq_pkg::*;
#(
    parameter int DEPTH = DEF_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic signed [DATA_W-1:0] i_item_value,
    output t_dp_stat                 o_stat,
    cfq_out_if.source                o_out
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [AW-1:0] r_walk, n_walk;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rem, n_rem;

    logic                     r_out_valid, n_out_valid;
    logic [ST_W-1:0]          r_status, n_status;
    logic                     r_has_data, n_has_data;
    logic signed [DATA_W-1:0] r_data, n_data;
    logic                     r_last, n_last;

    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              out_free;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
        return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
    endfunction

    assign rd_addr = i_cmd.rd_start ? r_head : r_walk;

    cfq_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.enq),
        .i_wr_addr(r_tail),
        .i_wr_data(i_item_value),
        .i_rd_en  (i_cmd.rd_start | i_cmd.rd_next),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    assign out_free        = !r_out_valid || o_out.ready;
    assign o_stat.full     = (r_count == CW'(DEPTH));
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.out_free = out_free;
    assign o_stat.rem_one  = (r_rem == CW'(1));

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_walk  = r_walk;
        n_count = r_count;
        n_rem   = r_rem;
        if (i_cmd.enq) begin
            n_tail  = wrap_inc(r_tail);
            n_count = r_count + CW'(1);
        end
        if (i_cmd.deq_adv) begin
            n_head  = wrap_inc(r_head);
            n_count = r_count - CW'(1);
        end
        if (i_cmd.rd_start) begin
            n_walk = wrap_inc(r_head);
            n_rem  = r_count;
        end else if (i_cmd.rd_next) begin
            n_walk = wrap_inc(r_walk);
        end
        if (i_cmd.ld_data) begin
            n_rem = r_rem - CW'(1);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !o_out.ready;
        n_status    = r_status;
        n_has_data  = r_has_data;
        n_data      = r_data;
        n_last      = r_last;
        priority if (i_cmd.ld_ovf) begin
            n_out_valid = 1'b1;
            n_status    = ST_OVERFLOW;
            n_has_data  = 1'b0;
            n_data      = '0;
            n_last      = 1'b1;
        end else if (i_cmd.ld_empty) begin
            n_out_valid = 1'b1;
            n_status    = ST_EMPTY;
            n_has_data  = 1'b0;
            n_data      = '0;
            n_last      = 1'b1;
        end else if (i_cmd.enq) begin
            n_out_valid = 1'b1;
            n_status    = ST_OK;
            n_has_data  = 1'b0;
            n_data      = '0;
            n_last      = 1'b1;
        end else if (i_cmd.ld_data) begin
            n_out_valid = 1'b1;
            n_status    = ST_OK;
            n_has_data  = 1'b1;
            n_data      = rd_data;
            n_last      = i_cmd.ld_last;
        end else begin
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_walk      <= '0;
            r_count     <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_walk      <= n_walk;
            r_count     <= n_count;
            r_rem       <= n_rem;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_has_data <= n_has_data;
        r_data     <= n_data;
        r_last     <= n_last;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_status;
    assign o_out.has_data   = r_has_data;
    assign o_out.data_value = r_data;
    assign o_out.last       = r_last;

endmodule

// ===== src/cfq_ctrl.sv =====
module cfq_ctrl
    import cfq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    cfq_in_if.sink   i_in,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_is_disp, n_is_disp;
    logic       accept;

    assign i_in.ready = (r_state == S_IDLE) && i_stat.out_free;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_state   = r_state;
        n_is_disp = r_is_disp;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_in.opcode)
                        OP_ENQUEUE: begin
                            o_cmd.ld_ovf = i_stat.full;
                            o_cmd.enq    = !i_stat.full;
                        end
                        OP_DEQUEUE, OP_DISPLAY: begin
                            if (i_stat.empty) begin
                                o_cmd.ld_empty = 1'b1;
                            end else begin
                                o_cmd.rd_start = 1'b1;
                                n_is_disp      = (i_in.opcode == OP_DISPLAY);
                                n_state        = S_RD;
                            end
                        end
                        default: begin
                            // unused opcode: dropped silently
                        end
                    endcase
                end
            end
            S_RD: begin
                // read data is out of the RAM; output register was freed at issue
                o_cmd.ld_data = 1'b1;
                o_cmd.ld_last = !r_is_disp || i_stat.rem_one;
                o_cmd.deq_adv = !r_is_disp;
                n_state       = (!r_is_disp || i_stat.rem_one) ? S_IDLE : S_WALK;
            end
            S_WALK: begin
                if (i_stat.out_free) begin
                    o_cmd.rd_next = 1'b1;
                    n_state       = S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_is_disp <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_is_disp <= n_is_disp;
        end
    end

endmodule

// ===== src/circular_fifo_queue_unit.sv =====
// Enqueue: result beat valid in the cycle after accept; one enqueue per cycle while output drains.
// Dequeue: result passes through the registered RAM read, then the output register.
// Display: one beat per stored entry, each a RAM read, then a load of the output register.
// Each input item is accepted only when the previous one is fully emitted and the
// output register is free. Reset (i_rst_n low, synchronous) empties the queue
// and clears the pointers and output valid; entry storage is not cleared.
module circular_fifo_queue_unit
    import cfq_pkg::*;
#(
    parameter int DEPTH = DEF_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cfq_in_if.sink    i_in,
    cfq_out_if.source o_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    cfq_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (i_in),
        .i_stat (stat),
        .o_cmd  (cmd)
    );

    cfq_dp #(
        .DEPTH(DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item_value(i_in.item_value),
        .o_stat      (stat),
        .o_out       (o_out)
    );

endmodule

// ===== src/cfq_checker.sv =====
module cfq_checker
    import cfq_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [ST_W-1:0]   i_out_status,
    input logic              i_out_has_data,
    input logic [DATA_W-1:0] i_out_data,
    input logic              i_out_last
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_status) && $stable(i_out_data)
            && $stable(i_out_has_data) && $stable(i_out_last))
        else $error("output beat changed while stalled");

    a_no_data_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status == ST_EMPTY || i_out_status == ST_OVERFLOW)
            |-> !i_out_has_data && i_out_last && (i_out_data == '0))
        else $error("error status beat carries data or is not last");

    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_has_data |-> (i_out_status == ST_OK))
        else $error("data beat without ok status");

    // mid-display the input side stays closed
    a_walk_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input accepted while display still emitting");

endmodule

bind circular_fifo_queue_unit cfq_checker u_cfq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_status  (o_out.status),
    .i_out_has_data(o_out.has_data),
    .i_out_data    (o_out.data_value),
    .i_out_last    (o_out.last)
);

// ===== tb/cfq_result_checker.sv =====
module cfq_result_checker
    import cfq_pkg::*;
#(
    parameter int DEPTH = DEF_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cfq_in_if    i_in,
    cfq_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic                     has_data;
        logic signed [DATA_W-1:0] data_value;
        logic                     last;
    } t_queue_result;

    // shadow copy of the queue contents and pointers
    logic signed [DATA_W-1:0] shadow_store [DEPTH];
    logic [IDX_W-1:0]         shadow_head;
    logic [IDX_W-1:0]         shadow_tail;
    logic [CNT_W-1:0]         shadow_count;

    t_queue_result expected_results[$];
    int            fail_count;

    function automatic logic [IDX_W-1:0] wrap_index(input logic [IDX_W-1:0] idx);
        return (int'(idx) == DEPTH - 1) ? '0 : idx + IDX_W'(1);
    endfunction

    task automatic predict_queue_op(input logic [OP_W-1:0] op,
                                    input logic signed [DATA_W-1:0] value);
        logic [IDX_W-1:0] walk;
        case (op)
            OP_ENQUEUE: begin
                if (int'(shadow_count) == DEPTH) begin
                    expected_results.push_back('{ST_OVERFLOW, 1'b0, '0, 1'b1});
                end else begin
                    shadow_store[shadow_tail] = value;
                    shadow_tail  = wrap_index(shadow_tail);
                    shadow_count = shadow_count + CNT_W'(1);
                    expected_results.push_back('{ST_OK, 1'b0, '0, 1'b1});
                end
            end
            OP_DEQUEUE: begin
                if (shadow_count == 0) begin
                    expected_results.push_back('{ST_EMPTY, 1'b0, '0, 1'b1});
                end else begin
                    expected_results.push_back('{ST_OK, 1'b1, shadow_store[shadow_head], 1'b1});
                    shadow_head  = wrap_index(shadow_head);
                    shadow_count = shadow_count - CNT_W'(1);
                end
            end
            OP_DISPLAY: begin
                if (shadow_count == 0) begin
                    expected_results.push_back('{ST_EMPTY, 1'b0, '0, 1'b1});
                end else begin
                    walk = shadow_head;
                    for (int i = 0; i < int'(shadow_count); i++) begin
                        expected_results.push_back('{ST_OK, 1'b1, shadow_store[walk],
                                                     i == int'(shadow_count) - 1});
                        walk = wrap_index(walk);
                    end
                end
            end
            default: ;  // unused opcode: no beat, no state change
        endcase
    endtask

    always @(posedge i_clk) begin
        t_queue_result got;
        t_queue_result want;
        if (!i_rst_n) begin
            expected_results.delete();
            shadow_head  = '0;
            shadow_tail  = '0;
            shadow_count = '0;
            fail_count   = 0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                predict_queue_op(i_in.opcode, i_in.item_value);
            end
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.status, i_out.has_data, i_out.data_value, i_out.last};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat status=%0d has_data=%0b data=%0d last=%0b",
                             $time, got.status, got.has_data, got.data_value, got.last);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.has_data !== want.has_data ||
                        got.data_value !== want.data_value || got.last !== want.last) begin
                        $display("%0t: mismatch expected status=%0d has_data=%0b data=%0d last=%0b",
                                 $time, want.status, want.has_data, want.data_value, want.last);
                        $display("%0t:          actual   status=%0d has_data=%0b data=%0d last=%0b",
                                 $time, got.status, got.has_data, got.data_value, got.last);
                        fail_count++;
                    end
                end
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== tb/tb.sv =====
module tb;
    import cfq_pkg::*;

    localparam int DEPTH          = DEF_DEPTH;
    localparam int RANDOM_ITEMS   = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 16;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending_results;

    // stimulus-side bookkeeping only, used to steer fill/drain runs
    int   fill_level;
    int   items_sent;
    int   burst_left;

    cfq_in_if  in_bus();
    cfq_out_if out_bus();

    circular_fifo_queue_unit #(.DEPTH(DEPTH)) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus)
    );

    cfq_result_checker #(.DEPTH(DEPTH)) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_bus),
        .i_out       (out_bus),
        .o_fail_count(fail_count),
        .o_pending   (pending_results)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return OP_ENQUEUE;
        if (r < 88) return OP_DEQUEUE;
        if (r < 97) return OP_DISPLAY;
        return OP_UNUSED;
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_bus.valid      <= 1'b1;
        in_bus.opcode     <= op;
        in_bus.item_value <= value;
        do @(posedge i_clk); while (!in_bus.ready);
        burst_left--;
        if (op != OP_UNUSED) items_sent++;
        if (op == OP_ENQUEUE && fill_level < DEPTH) fill_level++;
        if (op == OP_DEQUEUE && fill_level > 0) fill_level--;
    endtask

    // hold the sender off until every predicted beat has come back
    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_results != 0);
    endtask

    // receiver: ready pattern switches mode every so often
    initial begin
        int mode;
        int span;
        int phase;
        out_bus.ready <= 1'b0;
        mode  = 0;
        span  = 0;
        phase = 0;
        forever begin
            @(posedge i_clk);
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(20, 200);
            end
            span--;
            phase++;
            case (mode)
                0: out_bus.ready <= 1'b1;
                1: out_bus.ready <= ($urandom_range(0, 3) != 0);
                2: out_bus.ready <= ($urandom_range(0, 3) == 0);
                default: out_bus.ready <= ((phase % 5) < 2);
            endcase
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n !== 1'b1 || (in_bus.valid && in_bus.ready) ||
                (out_bus.valid && out_bus.ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        int phase_kind;
        i_rst_n           <= 1'b0;
        in_bus.valid      <= 1'b0;
        in_bus.opcode     <= OP_ENQUEUE;
        in_bus.item_value <= '0;
        fill_level = 0;
        items_sent = 0;
        burst_left = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty cases, unused opcode, value extremes, walk and drain
        send_item(OP_DISPLAY, '0);
        send_item(OP_DEQUEUE, '0);
        send_item(OP_UNUSED, 32'sh1234_5678);
        send_item(OP_ENQUEUE, 32'sh7FFF_FFFF);
        send_item(OP_ENQUEUE, 32'sh8000_0000);
        send_item(OP_ENQUEUE, '0);
        send_item(OP_ENQUEUE, '1);
        send_item(OP_ENQUEUE, 32'sh5555_5555);
        send_item(OP_ENQUEUE, 32'shAAAA_AAAA);
        send_item(OP_DISPLAY, '1);
        send_item(OP_UNUSED, '1);
        repeat (6) send_item(OP_DEQUEUE, $urandom);
        send_item(OP_DEQUEUE, '0);
        send_item(OP_ENQUEUE, $urandom);
        send_item(OP_DISPLAY, '0);
        send_item(OP_DEQUEUE, '0);
        wait_drained();

        // random: fill-to-full and drain-to-empty runs, mixed traffic between
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            phase_kind = $urandom_range(0, 9);
            if (phase_kind <= 2) begin
                while (fill_level < DEPTH) begin
                    if ($urandom_range(0, 15) == 0) send_item(OP_DISPLAY, pick_value());
                    else send_item(OP_ENQUEUE, pick_value());
                end
                repeat ($urandom_range(1, 3)) send_item(OP_ENQUEUE, pick_value());
                if ($urandom_range(0, 1) == 0) send_item(OP_DISPLAY, pick_value());
            end else if (phase_kind <= 5) begin
                while (fill_level > 0) begin
                    if ($urandom_range(0, 15) == 0) send_item(OP_DISPLAY, pick_value());
                    else send_item(OP_DEQUEUE, pick_value());
                end
                repeat ($urandom_range(1, 2)) send_item(OP_DEQUEUE, pick_value());
                if ($urandom_range(0, 1) == 0) send_item(OP_DISPLAY, pick_value());
            end else if (phase_kind <= 8) begin
                repeat ($urandom_range(10, 40)) send_item(pick_op(), pick_value());
            end else begin
                wait_drained();
            end
        end

        in_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/cfq_pkg.sv
src/cfq_if.sv
src/cfq_ram.sv
src/cfq_dp.sv
src/cfq_ctrl.sv
src/circular_fifo_queue_unit.sv
src/cfq_checker.sv
tb/cfq_result_checker.sv
tb/tb.sv
